>>> rtl/isort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isort_pkg: shared types for the insertion sorter
// Value type and the command that steers every cell of the chain.
// ----------------------------------------------------------------------------
package isort_pkg;

  localparam int ValueWidth = 32;

  typedef logic signed [ValueWidth-1:0] value_t;

  // Per-cycle command broadcast to all cells
  typedef struct packed {
    logic insert;  // place the broadcast value, larger entries move up
    logic drain;   // every cell takes its upper neighbour, cell 0 leaves
  } cell_cmd_t;

endpackage : isort_pkg
`default_nettype wire

>>> rtl/isort_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isort_in_if: input item channel
// Valid/ready channel carrying one value to be sorted.
// ----------------------------------------------------------------------------
interface isort_in_if
  import isort_pkg::*;
();
  logic   valid;
  logic   ready;
  value_t value;
  logic   end_of_list;

  modport source (output valid, output value, output end_of_list, input ready);
  modport sink (input valid, input value, input end_of_list, output ready);
endinterface : isort_in_if
`default_nettype wire

>>> rtl/isort_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isort_out_if: result item channel
// Valid/ready channel carrying one sorted value with its run flags.
// ----------------------------------------------------------------------------
interface isort_out_if
  import isort_pkg::*;
();
  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   last_out;
  logic   dropped;

  modport source (output valid, output sorted_value, output last_out, output dropped,
                  input ready);
  modport sink (input valid, input sorted_value, input last_out, input dropped,
                output ready);
endinterface : isort_out_if
`default_nettype wire

>>> rtl/isort_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isort_cell: one slot of the sorting chain
// Holds one value; compares with the broadcast value and swaps with neighbours.
// ----------------------------------------------------------------------------
module isort_cell
  import isort_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_cmd_t cmd,
  input  wire value_t    new_value,
  input  wire value_t    left_value,
  input  wire logic      left_occupied,
  input  wire logic      left_greater,
  input  wire value_t    right_value,
  input  wire logic      right_occupied,
  output value_t         held_value,
  output logic           occupied,
  output logic           greater
);

  value_t held_value_next;
  logic   occupied_next;

  // strictly greater only, so equal values keep arrival order
  assign greater = occupied && (held_value > new_value);

  always_comb begin
    held_value_next = held_value;
    occupied_next   = occupied;
    if (cmd.drain) begin
      held_value_next = right_value;
      occupied_next   = right_occupied;
    end else if (cmd.insert) begin
      if (greater || (!occupied && left_occupied)) begin
        held_value_next = left_greater ? left_value : new_value;
        occupied_next   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else begin
      occupied <= occupied_next;
    end
  end

  always_ff @(posedge clk) begin
    held_value <= held_value_next;
  end

endmodule : isort_cell
`default_nettype wire

>>> rtl/insertion_sorter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sorter: stable ascending sort of a list of signed values
// Chain of CAPACITY cells; values are inserted in place, one per cycle.
// ----------------------------------------------------------------------------
// Use:
//   values : one signed value per item; end_of_list closes the list.
//   sorted : the held values in ascending order, last_out on the largest,
//            dropped on every item of the run if any value did not fit.
// During loading every cell compares the broadcast value with its own at once
// and the larger entries move up one cell, so a new item can follow in the
// very next cycle.
// After the item with end_of_list is taken, the first result appears in the
// next cycle and the chain unloads one item per cycle from cell 0, all cells
// shifting down together. No input is taken until the final result has gone.
// At most CAPACITY values of a run are held, and each held value is unloaded.
// Values arriving while all cells are full are discarded and flagged.
// A stalled receiver simply freezes the chain; nothing is lost.
// Reset empties the chain and clears the overflow flag.
// ----------------------------------------------------------------------------
module insertion_sorter
  import isort_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  isort_in_if.sink    values,
  isort_out_if.source sorted
);

  value_t    cell_value [CAPACITY];
  logic      cell_occ   [CAPACITY];
  logic      cell_gt    [CAPACITY];
  cell_cmd_t cmd;

  logic draining;
  logic draining_next;
  logic overflow;
  logic overflow_next;

  logic in_take;
  logic out_take;
  logic full;

  assign full      = cell_occ[CAPACITY-1];
  assign in_take   = values.valid && values.ready;
  assign out_take  = sorted.valid && sorted.ready;

  // no loading while a run is being unloaded
  assign values.ready = !draining;

  assign cmd.insert = in_take && !full;
  assign cmd.drain  = out_take;

  // cell 0 is the output register; during unload it is always occupied
  assign sorted.valid        = draining;
  assign sorted.sorted_value = cell_value[0];
  assign sorted.last_out     = !cell_occ[1];
  assign sorted.dropped      = overflow;

  // chain of cells: left is the lower slot, right the upper
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_value;
    logic   left_occ;
    logic   left_gt;
    value_t right_value;
    logic   right_occ;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_occ   = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_inner_left
      assign left_value = cell_value[i-1];
      assign left_occ   = cell_occ[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
      assign right_occ   = 1'b0;
    end else begin : g_inner_right
      assign right_value = cell_value[i+1];
      assign right_occ   = cell_occ[i+1];
    end

    isort_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .cmd            (cmd),
      .new_value      (values.value),
      .left_value     (left_value),
      .left_occupied  (left_occ),
      .left_greater   (left_gt),
      .right_value    (right_value),
      .right_occupied (right_occ),
      .held_value     (cell_value[i]),
      .occupied       (cell_occ[i]),
      .greater        (cell_gt[i])
    );
  end

  // run control: unload starts after end_of_list, ends on the final result
  always_comb begin
    draining_next = draining;
    overflow_next = overflow;
    if (in_take) begin
      if (full) begin
        overflow_next = 1'b1;
      end
      if (values.end_of_list) begin
        draining_next = 1'b1;
      end
    end
    if (out_take && sorted.last_out) begin
      draining_next = 1'b0;
      overflow_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      overflow <= 1'b0;
    end else begin
      draining <= draining_next;
      overflow <= overflow_next;
    end
  end

endmodule : insertion_sorter
`default_nettype wire
